@@ hw/rtl/base64_stream_decoder_top_assert.svh @@
// Assertion macros used by the decoder's top-level RTL file.
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define B64D_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64d: check failed");
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64d: check failed");
`else
`define B64D_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/b64d_pkg.sv @@
package b64d_pkg;

   localparam logic [7:0] PadChar   = 8'h3D;
   localparam logic [7:0] PrintLow  = 8'h20;
   localparam logic [7:0] PrintHigh = 8'h7E;
   localparam logic [5:0] MaskHigh2 = 6'h30;
   localparam logic [5:0] MaskLow4  = 6'h0F;
   localparam logic [5:0] MaskMid4  = 6'h3C;
   localparam logic [5:0] MaskLow2  = 6'h03;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       string_done;
      logic       bad_input;
   } rsp_type;

   // Decodes one character of the standard alphabet; hit is low for anything else.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      logic [7:0] d;
      s.hit = 1'b1;
      d     = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = c - 8'h47;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d = c + 8'h04;
      end else if (c == 8'h2B) begin
         d = 8'd62;
      end else if (c == 8'h2F) begin
         d = 8'd63;
      end else begin
         s.hit = 1'b0;
      end
      s.value = d[5:0];
      return s;
   endfunction

endpackage

@@ hw/rtl/b64d_decode.sv @@
module b64d_decode
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] ch,
   input  logic       end_of_text,
   input  logic       step,
   output logic       has_result,
   output rsp_type    result
);

   logic [1:0] pos_ff,     pos_in;
   logic [5:0] prior_ff,   prior_in;
   logic       stopped_ff, stopped_in;
   logic       failed_ff,  failed_in;

   sextet_type sx;
   logic       active;
   logic       is_pad;
   logic       stop_hit;
   logic       fail_hit;
   logic       take;
   logic [5:0] v;
   logic [7:0] byte_val;
   logic       got;
   logic [1:0] pos_next;
   logic [5:0] prior_next;
   logic       stopped_next;
   logic       failed_next;

   always_comb begin
      sx       = sextet_of(ch);
      active   = !stopped_ff && !failed_ff && ch >= PrintLow && ch <= PrintHigh;
      is_pad   = (ch == PadChar);
      stop_hit = active && pos_ff[1] && is_pad;
      fail_hit = active && !stop_hit && !sx.hit && !pos_ff[1] && !is_pad;
      take     = active && !stop_hit && !fail_hit;
      v        = sx.hit ? sx.value : 6'd0;

      unique case (pos_ff)
         2'd1:    byte_val = {prior_ff, 2'b00} | {6'd0, 2'((v & MaskHigh2) >> 4)};
         2'd2:    byte_val = {4'(prior_ff & MaskLow4), 4'((v & MaskMid4) >> 2)};
         2'd3:    byte_val = {2'((prior_ff & MaskLow2) >> 0), v};
         default: byte_val = 8'h00;
      endcase
      got = take && (pos_ff != 2'd0);

      pos_next     = take ? pos_ff + 2'd1 : pos_ff;
      prior_next   = take ? v : prior_ff;
      stopped_next = stopped_ff || stop_hit;
      failed_next  = failed_ff || fail_hit;

      // A string that ends after the first character of a group is padded out.
      if (end_of_text && !stopped_next && !failed_next && pos_next == 2'd1) begin
         byte_val = {prior_next, 2'b00};
         got      = 1'b1;
      end

      has_result         = got || end_of_text;
      result.data_byte   = got ? byte_val : 8'h00;
      result.byte_valid  = got;
      result.string_done = end_of_text;
      result.bad_input   = end_of_text && failed_next;

      pos_in     = pos_ff;
      prior_in   = prior_ff;
      stopped_in = stopped_ff;
      failed_in  = failed_ff;
      if (step) begin
         if (end_of_text) begin
            pos_in     = 2'd0;
            prior_in   = 6'd0;
            stopped_in = 1'b0;
            failed_in  = 1'b0;
         end else begin
            pos_in     = pos_next;
            prior_in   = prior_next;
            stopped_in = stopped_next;
            failed_in  = failed_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 2'd0;
         prior_ff   <= 6'd0;
         stopped_ff <= 1'b0;
         failed_ff  <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         prior_ff   <= prior_in;
         stopped_ff <= stopped_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

@@ hw/rtl/b64d_out_reg.sv @@
module b64d_out_reg
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  logic    load_valid,
   input  rsp_type load_data,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   output logic    can_load
);

   logic    valid_ff, valid_in;
   rsp_type data_ff,  data_in;

   // The register takes a new beat when it is empty or its beat leaves this cycle.
   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (can_load) begin
         valid_in = load && load_valid;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ hw/rtl/base64_stream_decoder_top.sv @@
// Base64 stream decoder.
// The req channel carries one character a beat (req_ch) with req_end_of_text
// marking the last character of a string. The rsp channel carries at most one
// beat per character: a decoded byte (rsp_byte_valid high), the closing beat of
// a string (rsp_string_done high, rsp_bad_input high if an illegal character
// aborted it), or both. Characters that produce neither give no rsp beat.
// A character is accepted at an edge where req_valid is high and req_stall low.
// It is held in the input register, is decoded against the group state and
// lands in the result register, from which its rsp beat is offered. One
// character can be accepted every cycle while the result register can take a
// beat; the single combinational decode step between the two registers sets
// that figure.
// Reset empties both registers and clears the decoder state, so the first character
// after reset starts a new string. While rsp_stall is high and the result
// register is full, the input register holds its character and req_stall
// rises once the input register is also full; nothing is dropped.
`include "base64_stream_decoder_top_assert.svh"

module base64_stream_decoder_top
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_done,
   output logic       rsp_bad_input
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_ch_ff,    s1_ch_in;
   logic       s1_eot_ff,   s1_eot_in;

   logic    advance;
   logic    step;
   logic    has_result;
   rsp_type result;
   rsp_type rsp_data;

   assign req_stall = s1_valid_ff && !advance;
   assign step      = s1_valid_ff && advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ch_in    = s1_ch_ff;
      s1_eot_in   = s1_eot_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_ch_in    = req_ch;
         s1_eot_in   = req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_ch_ff  <= s1_ch_in;
      s1_eot_ff <= s1_eot_in;
   end

   b64d_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .ch          (s1_ch_ff),
      .end_of_text (s1_eot_ff),
      .step        (step),
      .has_result  (has_result),
      .result      (result)
   );

   b64d_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_valid_ff),
      .load_valid (has_result),
      .load_data  (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .can_load   (advance)
   );

   assign rsp_data_byte   = rsp_data.data_byte;
   assign rsp_byte_valid  = rsp_data.byte_valid;
   assign rsp_string_done = rsp_data.string_done;
   assign rsp_bad_input   = rsp_data.bad_input;

   `B64D_ASSERT_IMPLY(a_zero_when_no_byte, clock, reset,
      rsp_valid && !rsp_byte_valid, rsp_data_byte == 8'h00)
   `B64D_ASSERT_IMPLY(a_bad_only_on_close, clock, reset,
      rsp_valid && rsp_bad_input, rsp_string_done)
   `B64D_ASSERT_IMPLY(a_stall_only_when_full, clock, reset,
      req_stall, s1_valid_ff && rsp_valid && rsp_stall)
   `B64D_ASSERT_NEXT(a_accept_fills_input, clock, reset,
      req_valid && !req_stall, s1_valid_ff)

endmodule

@@ tb/tb.sv @@
module tb;
   import b64d_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int RandomChars = 1500;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
      logic       typed;
      logic       has_rsp;
      rsp_type    rsp;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_string_done;
   logic       rsp_bad_input;

   // Decoder state as the predictor sees it.
   logic [1:0] grp_pos = 2'd0;
   logic [5:0] prior   = 6'd0;
   logic       pad_stop = 1'b0;
   logic       aborted  = 1'b0;

   rsp_type      decoded_due[$];
   stim_row_type table_rows[$];
   int           fail_count = 0;
   int           cycle_count = 0;

   base64_stream_decoder_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_string_done (rsp_string_done),
      .rsp_bad_input   (rsp_bad_input)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic sextet_type alphabet_value(input logic [7:0] c);
      sextet_type s;
      s.hit   = 1'b1;
      s.value = 6'd0;
      if (c >= "A" && c <= "Z") s.value = 6'(c - "A");
      else if (c >= "a" && c <= "z") s.value = 6'(c - "a" + 26);
      else if (c >= "0" && c <= "9") s.value = 6'(c - "0" + 52);
      else if (c == "+") s.value = 6'd62;
      else if (c == "/") s.value = 6'd63;
      else s.hit = 1'b0;
      return s;
   endfunction

   function automatic logic [7:0] alphabet_char(input int idx);
      if (idx < 26) return 8'("A" + idx);
      if (idx < 52) return 8'("a" + idx - 26);
      if (idx < 62) return 8'("0" + idx - 52);
      if (idx == 62) return "+";
      return "/";
   endfunction

   // Advances the predicted decoder state by one character and reports the beat it causes.
   task automatic decode_char(input logic [7:0] c, input logic eot,
                              output bit got_rsp, output rsp_type r);
      sextet_type s;
      logic [5:0] v;
      logic [7:0] b;
      bit got;
      got = 1'b0;
      b   = 8'h00;
      if (!pad_stop && !aborted && c >= PrintLow && c <= PrintHigh) begin
         s = alphabet_value(c);
         if (grp_pos >= 2'd2 && c == PadChar) begin
            pad_stop = 1'b1;
         end else if (!s.hit && grp_pos < 2'd2 && c != PadChar) begin
            aborted = 1'b1;
         end else begin
            v = s.hit ? s.value : 6'd0;
            case (grp_pos)
               2'd1: begin
                  b = {prior, v[5:4]};
                  got = 1'b1;
               end
               2'd2: begin
                  b = {prior[3:0], v[5:2]};
                  got = 1'b1;
               end
               2'd3: begin
                  b = {prior[1:0], v};
                  got = 1'b1;
               end
               default: ;
            endcase
            prior = v;
            grp_pos = grp_pos + 2'd1;
         end
      end
      r.data_byte   = 8'h00;
      r.byte_valid  = 1'b0;
      r.string_done = eot;
      r.bad_input   = eot & aborted;
      if (eot && !pad_stop && !aborted && grp_pos == 2'd1) begin
         b = {prior, 2'b00};
         got = 1'b1;
      end
      if (got) begin
         r.data_byte  = b;
         r.byte_valid = 1'b1;
      end
      got_rsp = got || eot;
      if (eot) begin
         grp_pos  = 2'd0;
         prior    = 6'd0;
         pad_stop = 1'b0;
         aborted  = 1'b0;
      end
   endtask

   function automatic stim_row_type row(input logic [7:0] c, input logic eot, input logic typed,
                                        input logic has_rsp, input logic [7:0] b,
                                        input logic bv, input logic done, input logic bad);
      stim_row_type it;
      it.ch      = c;
      it.eot     = eot;
      it.typed   = typed;
      it.has_rsp = has_rsp;
      it.rsp     = '{data_byte: b, byte_valid: bv, string_done: done, bad_input: bad};
      return it;
   endfunction

   function automatic stim_row_type plain(input logic [7:0] c, input logic eot);
      return row(c, eot, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
   endfunction

   // Offers one character and records its expected beat once acceptance is certain.
   task automatic send(input stim_row_type it, input int gap);
      bit got;
      rsp_type r;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_ch          <= it.ch;
      req_end_of_text <= it.eot;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      decode_char(it.ch, it.eot, got, r);
      if (it.typed) begin
         got = it.has_rsp;
         r   = it.rsp;
      end
      if (got) decoded_due.push_back(r);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (decoded_due.size() != 0) @(posedge clock);
   endtask

   // Consumer side: a random hold-off before each beat, with calm stretches.
   initial begin
      int n;
      int beats;
      bit calm;
      beats = 0;
      calm  = 1'b0;
      forever begin
         n = calm ? 0 : $urandom_range(0, 18);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
         while (!(rsp_valid === 1'b1 && !reset)) @(negedge clock);
         @(posedge clock);
         beats++;
         if (beats % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      end
   end

   // The beat seen here is taken at the coming rising edge.
   always @(negedge clock) begin : check_beat
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (decoded_due.size() == 0) begin
            $error("unexpected beat: data_byte %h byte_valid %b string_done %b bad_input %b",
                   rsp_data_byte, rsp_byte_valid, rsp_string_done, rsp_bad_input);
            fail_count++;
         end else begin
            want = decoded_due.pop_front();
            if (rsp_data_byte !== want.data_byte) begin
               $error("data_byte: expected %h, got %h", want.data_byte, rsp_data_byte);
               fail_count++;
            end
            if (rsp_byte_valid !== want.byte_valid) begin
               $error("byte_valid: expected %b, got %b", want.byte_valid, rsp_byte_valid);
               fail_count++;
            end
            if (rsp_string_done !== want.string_done) begin
               $error("string_done: expected %b, got %b", want.string_done, rsp_string_done);
               fail_count++;
            end
            if (rsp_bad_input !== want.bad_input) begin
               $error("bad_input: expected %b, got %b", want.bad_input, rsp_bad_input);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int sent;
      int next_pause;
      int len;
      int pads;
      int pick;
      bit calm;
      bit tidy;
      logic [7:0] c;

      // A lone pad still leaves one character in the group, so it closes with a zero byte.
      table_rows.push_back(row(PadChar, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0));
      table_rows.push_back(row("!", 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
      table_rows.push_back(row("A", 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1));
      table_rows.push_back(row("/", 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
      table_rows.push_back(row("/", 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0));
      table_rows.push_back(row("/", 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0));
      table_rows.push_back(row("/", 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0));
      table_rows.push_back(row("A", 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0));
      table_rows.push_back(row(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
      table_rows.push_back(row(8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
      table_rows.push_back(plain("T", 1'b0));
      table_rows.push_back(plain(8'h7F, 1'b0));
      table_rows.push_back(plain("W", 1'b0));
      table_rows.push_back(plain(8'h1F, 1'b0));
      table_rows.push_back(plain("F", 1'b0));
      table_rows.push_back(plain("u", 1'b1));
      // A printable non-alphabet character in the third place counts as zero.
      table_rows.push_back(plain("z", 1'b0));
      table_rows.push_back(plain("9", 1'b0));
      table_rows.push_back(plain("~", 1'b0));
      table_rows.push_back(plain("+", 1'b0));
      table_rows.push_back(plain(PadChar, 1'b0));
      table_rows.push_back(plain("A", 1'b1));
      table_rows.push_back(plain("Q", 1'b0));
      table_rows.push_back(plain(PadChar, 1'b0));
      table_rows.push_back(plain(PadChar, 1'b0));
      table_rows.push_back(plain(" ", 1'b1));
      table_rows.push_back(plain(" ", 1'b0));
      table_rows.push_back(plain("B", 1'b1));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (table_rows[i]) send(table_rows[i], $urandom_range(0, 3));
      drain();

      sent = 0;
      next_pause = 500;
      while (sent < RandomChars) begin
         calm = ($urandom_range(0, 4) == 0);
         tidy = ($urandom_range(0, 9) < 6);
         if (tidy) begin
            // Whole groups of alphabet characters, sometimes closed with one or two pads.
            len  = 4 * $urandom_range(1, 5);
            pads = $urandom_range(0, 2);
         end else begin
            len  = ($urandom_range(0, 19) == 0) ? 40 : $urandom_range(1, 20);
            pads = 0;
         end
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (tidy || pick < 80) c = alphabet_char($urandom_range(0, 63));
            else if (pick < 87) c = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                          : 8'($urandom_range(127, 255));
            else if (pick < 93) c = PadChar;
            else c = 8'($urandom_range(32, 126));
            if (tidy && i >= len - pads) c = PadChar;
            send(plain(c, i == len - 1), calm ? 0 : $urandom_range(0, 18));
            sent++;
         end
         if (sent >= next_pause) begin
            drain();
            next_pause += 500;
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_decode.sv
hw/rtl/b64d_out_reg.sv
hw/rtl/base64_stream_decoder_top.sv
tb/tb.sv
